// ===== rtl/core/btpc_pkg.sv =====
// Package for the barometric compensation core: item types, coefficient
// bundle, inter-stage payloads and fixed constants. No dependencies.
package btpc_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_CALIB_TEMP = 2'd0;
  localparam logic [1:0] REG_PRESS_A    = 2'd1;
  localparam logic [1:0] REG_PRESS_B    = 2'd2;
  localparam logic [1:0] REG_P9         = 2'd3;

  // Fixed constants of the compensation formula
  localparam logic signed [31:0] FINE_OFS  = 32'sd128000;
  localparam logic [20:0]        P_BASE    = 21'd1048576;
  localparam logic [15:0]        NUM_SCALE = 16'd3125;
  localparam logic [35:0]        T_ROUND   = 36'd128;
  localparam logic [35:0]        T_SCALE   = 36'd5;
  localparam logic [63:0]        DIV_BIAS  = 64'h0000_8000_0000_0000;
  localparam int unsigned        DIV_STEPS = 64;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] temp_centi;
    logic [31:0]        press_q24_8;
    logic               div_zero;
  } out_item_t;

  // Coefficients unpacked from the calibration registers
  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } calib_t;

  // Front end to divider
  typedef struct packed {
    logic [63:0]        numer;
    logic [30:0]        divis;
    logic signed [15:0] temp;
  } front_item_t;

  // Divider to back end
  typedef struct packed {
    logic [63:0]        quot;
    logic               zero;
    logic signed [15:0] temp;
  } div_item_t;

endpackage

// ===== rtl/core/btpc_front.sv =====
// Front pipeline: fine temperature, temperature output, divisor and numerator.
// Eight register stages. Depends on btpc_pkg.
module btpc_front import btpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  in_item_t    data_i,
  input  calib_t      cal_i,
  output logic        valid_o,
  output front_item_t data_o
);

  logic [7:0] vld_q;

  // stage regs
  logic signed [33:0] s1_ta_q;
  logic [31:0]        s1_dd_q;
  logic [19:0]        s1_rp_q, s2_rp_q, s3_rp_q, s4_rp_q, s5_rp_q, s6_rp_q;
  logic signed [22:0] s2_at_q;
  logic signed [36:0] s2_b1_q;
  logic signed [31:0] s3_fine_q;
  logic signed [15:0] s4_temp_q, s5_temp_q, s6_temp_q, s7_temp_q, s8_temp_q;
  logic signed [31:0] s4_pa_q;
  logic signed [63:0] s5_sq_q;
  logic signed [47:0] s5_ap5_q, s5_ap2_q, s6_ap5_q, s6_ap2_q;
  logic [63:0]        s6_m6_q, s6_m3_q;
  logic [63:0]        s7_bsum_q, s7_a2_q, s7_nb_q;
  logic [63:0]        s8_dv_q, s8_nm_q;

  logic signed [17:0] tdiff;
  logic signed [16:0] dlt;
  logic signed [33:0] ta, dsq;
  logic signed [36:0] b1;
  logic signed [31:0] fine;
  logic [35:0]        tt;
  logic signed [27:0] tv;
  logic signed [15:0] tsat;
  logic signed [63:0] w6, w3;
  logic [63:0]        bsum, a2, nb;
  logic [63:0]        wdv, wnm;

  // stage 1: temperature differences and products
  always_comb begin
    tdiff = $signed({1'b0, data_i.raw_temp[19:3]}) - $signed({1'b0, cal_i.t1, 1'b0});
    dlt   = $signed({1'b0, data_i.raw_temp[19:4]}) - $signed({1'b0, cal_i.t1});
    ta    = 34'(tdiff) * 34'($signed(cal_i.t2));
    dsq   = 34'(dlt) * 34'(dlt);
  end

  // stage 2: scale the squared term by T3
  assign b1 = 37'($signed({1'b0, s1_dd_q[31:12]})) * 37'($signed(cal_i.t3));

  // stage 3: fine temperature
  assign fine = {{9{s2_at_q[22]}}, s2_at_q} + {{9{s2_b1_q[36]}}, s2_b1_q[36:14]};

  // stage 4: temperature in centidegrees, saturated
  always_comb begin
    tt = {{4{s3_fine_q[31]}}, s3_fine_q} * T_SCALE + T_ROUND;
    tv = tt[35:8];
    if (tv > 28'sd32767) begin
      tsat = 16'sh7fff;
    end else if (tv < -28'sd32768) begin
      tsat = 16'sh8000;
    end else begin
      tsat = tv[15:0];
    end
  end

  // stage 6: squared term times P6 and P3, kept modulo 2^64
  always_comb begin
    w6 = s5_sq_q * 64'($signed(cal_i.p6));
    w3 = s5_sq_q * 64'($signed(cal_i.p3));
  end

  // stage 7: accumulate the divisor and numerator offsets
  always_comb begin
    bsum = s6_m6_q + ({{16{s6_ap5_q[47]}}, s6_ap5_q} << 17)
         + ({{48{cal_i.p4[15]}}, cal_i.p4} << 35);
    a2   = {{8{s6_m3_q[63]}}, s6_m3_q[63:8]} + ({{16{s6_ap2_q[47]}}, s6_ap2_q} << 12);
    nb   = {12'b0, P_BASE - {1'b0, s6_rp_q}, 31'b0};
  end

  // stage 8: scale by P1 and by the numerator constant
  always_comb begin
    wdv = (DIV_BIAS + s7_a2_q) * {48'b0, cal_i.p1};
    wnm = (s7_nb_q - s7_bsum_q) * {48'b0, NUM_SCALE};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[6:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_ta_q   <= ta;
      s1_dd_q   <= dsq[31:0];
      s1_rp_q   <= data_i.raw_press;
      s2_at_q   <= s1_ta_q[33:11];
      s2_b1_q   <= b1;
      s2_rp_q   <= s1_rp_q;
      s3_fine_q <= fine;
      s3_rp_q   <= s2_rp_q;
      s4_temp_q <= tsat;
      s4_pa_q   <= s3_fine_q - FINE_OFS;
      s4_rp_q   <= s3_rp_q;
      s5_sq_q   <= 64'(s4_pa_q) * 64'(s4_pa_q);
      s5_ap5_q  <= 48'(s4_pa_q) * 48'($signed(cal_i.p5));
      s5_ap2_q  <= 48'(s4_pa_q) * 48'($signed(cal_i.p2));
      s5_temp_q <= s4_temp_q;
      s5_rp_q   <= s4_rp_q;
      s6_m6_q   <= w6;
      s6_m3_q   <= w3;
      s6_ap5_q  <= s5_ap5_q;
      s6_ap2_q  <= s5_ap2_q;
      s6_temp_q <= s5_temp_q;
      s6_rp_q   <= s5_rp_q;
      s7_bsum_q <= bsum;
      s7_a2_q   <= a2;
      s7_nb_q   <= nb;
      s7_temp_q <= s6_temp_q;
      s8_dv_q   <= wdv;
      s8_nm_q   <= wnm;
      s8_temp_q <= s7_temp_q;
    end
  end

  assign valid_o      = vld_q[7];
  assign data_o.numer = s8_nm_q;
  assign data_o.divis = s8_dv_q[63:33];
  assign data_o.temp  = s8_temp_q;

endmodule

// ===== rtl/core/btpc_div.sv =====
// Pipelined signed 64 by 31 bit divider, one quotient bit per stage,
// truncating toward zero. Depends on btpc_pkg.
module btpc_div import btpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  front_item_t data_i,
  output logic        valid_o,
  output div_item_t   data_o
);

  localparam int unsigned NV = DIV_STEPS + 2;

  logic [NV-1:0] vld_q;

  // per-step state; entry 0 is the input stage
  logic [30:0]        rem_q  [DIV_STEPS+1];
  logic [63:0]        quo_q  [DIV_STEPS+1];
  logic [30:0]        md_q   [DIV_STEPS+1];
  logic               neg_q  [DIV_STEPS+1];
  logic               zero_q [DIV_STEPS+1];
  logic signed [15:0] temp_q [DIV_STEPS+1];
  div_item_t          out_q;

  // input stage: magnitudes and result sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      quo_q[0]  <= data_i.numer[63] ? (64'd0 - data_i.numer) : data_i.numer;
      md_q[0]   <= data_i.divis[30] ? (31'd0 - data_i.divis) : data_i.divis;
      neg_q[0]  <= data_i.numer[63] ^ data_i.divis[30];
      zero_q[0] <= (data_i.divis == '0);
      temp_q[0] <= data_i.temp;
    end
  end

  // restoring steps
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [31:0] trial;
    logic        ge;
    logic [31:0] diff;
    always_comb begin
      trial = {rem_q[k], quo_q[k][63]};
      ge    = (trial >= {1'b0, md_q[k]});
      diff  = trial - {1'b0, md_q[k]};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? diff[30:0] : trial[30:0];
        quo_q[k+1]  <= {quo_q[k][62:0], ge};
        md_q[k+1]   <= md_q[k];
        neg_q[k+1]  <= neg_q[k];
        zero_q[k+1] <= zero_q[k];
        temp_q[k+1] <= temp_q[k];
      end
    end
  end

  // sign fix-up
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q.quot <= neg_q[DIV_STEPS] ? (64'd0 - quo_q[DIV_STEPS]) : quo_q[DIV_STEPS];
      out_q.zero <= zero_q[DIV_STEPS];
      out_q.temp <= temp_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NV-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[NV-1];
  assign data_o  = out_q;

endmodule

// ===== rtl/core/btpc_back.sv =====
// Back pipeline: P7..P9 correction, Q24.8 saturation and the output register.
// Four register stages. Depends on btpc_pkg.
module btpc_back import btpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  div_item_t data_i,
  input  calib_t    cal_i,
  output logic      valid_o,
  output out_item_t data_o
);

  logic [3:0] vld_q;

  logic [63:0]        b1_x_q, b1_m9_q, b1_m8_q, b1_q_q;
  logic [63:0]        b2_pp0_q, b2_m8_q, b2_q_q;
  logic [31:0]        b2_pp1_q, b2_pp2_q;
  logic [63:0]        b3_a9_q, b3_b8_q, b3_q_q;
  logic               b1_z_q, b2_z_q, b3_z_q;
  logic signed [15:0] b1_t_q, b2_t_q, b3_t_q;
  out_item_t          out_q;

  logic [63:0]        xs;
  logic signed [63:0] w9, w8;
  logic [63:0]        a9full, psum, pres;
  logic [31:0]        psat;

  // stage 1: P9 times q/2^13, P8 times q
  always_comb begin
    xs = {{13{data_i.quot[63]}}, data_i.quot[63:13]};
    w9 = 64'($signed(cal_i.p9)) * $signed(xs);
    w8 = 64'($signed(cal_i.p8)) * $signed(data_i.quot);
  end

  // stage 3: assemble the 64-bit product from its partials
  assign a9full = b2_pp0_q + {b2_pp1_q + b2_pp2_q, 32'b0};

  // stage 4: final sum and saturation
  always_comb begin
    psum = b3_q_q + b3_a9_q + b3_b8_q;
    pres = {{8{psum[63]}}, psum[63:8]} + ({{48{cal_i.p7[15]}}, cal_i.p7} << 4);
    if (b3_z_q || pres[63]) begin
      psat = '0;
    end else if (pres[63:32] != '0) begin
      psat = '1;
    end else begin
      psat = pres[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b1_x_q   <= xs;
      b1_m9_q  <= w9;
      b1_m8_q  <= w8;
      b1_q_q   <= data_i.quot;
      b1_z_q   <= data_i.zero;
      b1_t_q   <= data_i.temp;
      // stage 2: 32-bit partial products of the second P9 product
      b2_pp0_q <= {32'b0, b1_m9_q[31:0]} * {32'b0, b1_x_q[31:0]};
      b2_pp1_q <= b1_m9_q[31:0] * b1_x_q[63:32];
      b2_pp2_q <= b1_m9_q[63:32] * b1_x_q[31:0];
      b2_m8_q  <= b1_m8_q;
      b2_q_q   <= b1_q_q;
      b2_z_q   <= b1_z_q;
      b2_t_q   <= b1_t_q;
      b3_a9_q  <= {{25{a9full[63]}}, a9full[63:25]};
      b3_b8_q  <= {{19{b2_m8_q[63]}}, b2_m8_q[63:19]};
      b3_q_q   <= b2_q_q;
      b3_z_q   <= b2_z_q;
      b3_t_q   <= b2_t_q;
      out_q.temp_centi  <= b3_t_q;
      out_q.press_q24_8 <= psat;
      out_q.div_zero    <= b3_z_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  assign valid_o = vld_q[3];
  assign data_o  = out_q;

endmodule

// ===== rtl/core/baro_temp_pressure_compensation_core.sv =====
// Register stages from accepted input item to result: 8 front, 66 divider,
// 4 back. Throughput: one item per cycle; the whole pipeline freezes
// while a finished result is stalled at the output register.
// The divider is one quotient bit per stage, 64 stages, which sets the latency.
// Reset clears all valid bits and the calibration registers to zero.
// Top level: APB calibration registers and the three pipeline sections.
// Depends on btpc_pkg, btpc_front, btpc_div, btpc_back.
module baro_temp_pressure_compensation_core import btpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o
);

  logic [47:0] calib_temp_q;
  logic [63:0] calib_press_a_q, calib_press_b_q;
  logic [15:0] calib_p9_q;
  logic [1:0]  reg_idx;
  logic        wr_en, en;
  calib_t      cal;

  logic        f_valid, d_valid;
  front_item_t f_data;
  div_item_t   d_data;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_temp_q    <= '0;
      calib_press_a_q <= '0;
      calib_press_b_q <= '0;
      calib_p9_q      <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CALIB_TEMP: calib_temp_q    <= pwdata[47:0];
        REG_PRESS_A:    calib_press_a_q <= pwdata;
        REG_PRESS_B:    calib_press_b_q <= pwdata;
        REG_P9:         calib_p9_q      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      REG_CALIB_TEMP: prdata = {16'b0, calib_temp_q};
      REG_PRESS_A:    prdata = calib_press_a_q;
      REG_PRESS_B:    prdata = calib_press_b_q;
      REG_P9:         prdata = {48'b0, calib_p9_q};
      default:        prdata = '0;
    endcase
  end

  // coefficient unpacking
  always_comb begin
    cal.t1 = calib_temp_q[15:0];
    cal.t2 = calib_temp_q[31:16];
    cal.t3 = calib_temp_q[47:32];
    cal.p1 = calib_press_a_q[15:0];
    cal.p2 = calib_press_a_q[31:16];
    cal.p3 = calib_press_a_q[47:32];
    cal.p4 = calib_press_a_q[63:48];
    cal.p5 = calib_press_b_q[15:0];
    cal.p6 = calib_press_b_q[31:16];
    cal.p7 = calib_press_b_q[47:32];
    cal.p8 = calib_press_b_q[63:48];
    cal.p9 = calib_p9_q;
  end

  // global advance: hold everything while the output item is stalled
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  btpc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .cal_i   (cal),
    .valid_o (f_valid),
    .data_o  (f_data)
  );

  btpc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .data_i  (f_data),
    .valid_o (d_valid),
    .data_o  (d_data)
  );

  btpc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_valid),
    .data_i  (d_data),
    .cal_i   (cal),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

  // a zero divisor always forces pressure to zero
  a_divzero_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.div_zero |-> out_data_o.press_q24_8 == '0)
    else $error("div_zero item with nonzero pressure");

  // input is held off only by a stalled result
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // P9 write lands in its register
  a_p9_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && reg_idx == REG_P9 |=> calib_p9_q == $past(pwdata[15:0]))
    else $error("P9 register write lost");

endmodule

// ===== test/tb_baro_temp_pressure_compensation_core.sv =====
// Testbench for baro_temp_pressure_compensation_core: drives raw sample items and
// calibration writes, predicts each compensated result and checks it in order.
// Depends on btpc_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_baro_temp_pressure_compensation_core;
  import btpc_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_data_o;

  // Calibration shadow used by the predictor
  logic [63:0] cal_temp, cal_pa, cal_pb, cal_p9;

  out_item_t   comp_q[$];
  int          fail_cnt;
  int          sent_cnt;
  int          recv_cnt;
  int          zero_div_cnt;
  int          idle_in_pct;
  int          idle_out_pct;

  baro_temp_pressure_compensation_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Timeout at %0t", $time);
    $display("Test completed with failures");
    $finish;
  end

  // 64-bit helpers: arithmetic shift, sign extension, truncating division
  function automatic logic [63:0] sra64(input logic [63:0] v, input int s);
    return $signed(v) >>> s;
  endfunction

  function automatic logic [63:0] sx16(input logic [63:0] v);
    return {{48{v[15]}}, v[15:0]};
  endfunction

  function automatic logic [63:0] div_trunc(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] mn, md, q;
    mn = n[63] ? -n : n;
    md = d[63] ? -d : d;
    q  = (md != 0) ? mn / md : 64'd0;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  // Compensation of one raw sample pair under the current calibration
  function automatic out_item_t compensate(input in_item_t s);
    out_item_t   r;
    logic [63:0] adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] a, b, fine, d, p;
    logic signed [63:0] t;
    adc_t = {44'd0, s.raw_temp};
    adc_p = {44'd0, s.raw_press};
    t1 = {48'd0, cal_temp[15:0]};
    t2 = sx16(cal_temp >> 16);
    t3 = sx16(cal_temp >> 32);
    p1 = {48'd0, cal_pa[15:0]};
    p2 = sx16(cal_pa >> 16);
    p3 = sx16(cal_pa >> 32);
    p4 = sx16(cal_pa >> 48);
    p5 = sx16(cal_pb);
    p6 = sx16(cal_pb >> 16);
    p7 = sx16(cal_pb >> 32);
    p8 = sx16(cal_pb >> 48);
    p9 = sx16(cal_p9);
    // temperature
    a    = sra64(((adc_t >> 3) - (t1 << 1)) * t2, 11);
    d    = (adc_t >> 4) - t1;
    b    = sra64(sra64(d * d, 12) * t3, 14);
    fine = a + b;
    t    = sra64(fine * 64'd5 + 64'd128, 8);
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    r.temp_centi = t[15:0];
    // pressure
    a = fine - 64'd128000;
    b = a * a * p6;
    b = b + ((a * p5) << 17);
    b = b + (p4 << 35);
    a = sra64(a * a * p3, 8) + ((a * p2) << 12);
    a = sra64(((64'd1 << 47) + a) * p1, 33);
    if (a == 0) begin
      r.press_q24_8 = '0;
      r.div_zero    = 1'b1;
      return r;
    end
    p = 64'd1048576 - adc_p;
    p = div_trunc(((p << 31) - b) * 64'd3125, a);
    a = sra64(p9 * sra64(p, 13) * sra64(p, 13), 25);
    b = sra64(p8 * p, 19);
    p = sra64(p + a + b, 8) + (p7 << 4);
    if (p[63]) r.press_q24_8 = '0;
    else if (p[63:32] != 0) r.press_q24_8 = 32'hFFFF_FFFF;
    else r.press_q24_8 = p[31:0];
    r.div_zero = 1'b0;
    return r;
  endfunction

  // Receiver stall generator
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < idle_out_pct);
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (comp_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data_o);
        fail_cnt++;
      end else begin
        out_item_t ex;
        ex = comp_q.pop_front();
        recv_cnt++;
        if (ex.div_zero) zero_div_cnt++;
        if (ex.temp_centi !== out_data_o.temp_centi) begin
          $display("%0t: temp_centi expected %0d actual %0d", $time,
                   ex.temp_centi, out_data_o.temp_centi);
          fail_cnt++;
        end
        if (ex.press_q24_8 !== out_data_o.press_q24_8) begin
          $display("%0t: press_q24_8 expected %h actual %h", $time,
                   ex.press_q24_8, out_data_o.press_q24_8);
          fail_cnt++;
        end
        if (ex.div_zero !== out_data_o.div_zero) begin
          $display("%0t: div_zero expected %b actual %b", $time,
                   ex.div_zero, out_data_o.div_zero);
          fail_cnt++;
        end
      end
    end
  end

  // Send one sample item; called and returns on a rising edge
  task automatic send_sample(input logic [19:0] rt, input logic [19:0] rp);
    in_item_t s;
    s.raw_temp  = rt;
    s.raw_press = rp;
    // each cycle idles with the sender's idle probability
    while ($urandom_range(99) < idle_in_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    comp_q.push_back(compensate(s));
    sent_cnt++;
  endtask

  // Wait for the pipeline to empty
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (comp_q.size() != 0) @(posedge clk_i);
    repeat (90) @(posedge clk_i);
  endtask

  // APB write of one calibration register, only while idle
  task automatic write_calib(input logic [1:0] idx, input logic [63:0] val);
    drain_pipe();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_CALIB_TEMP: cal_temp = val & 64'h0000_FFFF_FFFF_FFFF;
      REG_PRESS_A:    cal_pa   = val;
      REG_PRESS_B:    cal_pb   = val;
      REG_P9:         cal_p9   = val & 64'hFFFF;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic load_calib(input logic [63:0] ct, input logic [63:0] pa,
                            input logic [63:0] pb, input logic [63:0] p9);
    write_calib(REG_CALIB_TEMP, ct);
    write_calib(REG_PRESS_A, pa);
    write_calib(REG_PRESS_B, pb);
    write_calib(REG_P9, p9);
  endtask

  // Typical datasheet-like coefficient set
  task automatic load_typical();
    load_calib({16'hFC18, 16'd26435, 16'd27504},
               {16'd2855, 16'd3024, 16'hD843, 16'd36477},
               {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
               64'd6000);
  endtask

  task automatic rand_calib();
    if ($urandom_range(1)) begin
      load_calib({$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
    end else begin
      // near-typical values so pressure lands in range
      load_calib({16'hFC18 ^ 16'($urandom_range(255)), 16'd26435 + 16'($urandom_range(511)),
                  16'd27504 + 16'($urandom_range(1023))},
                 {16'd2855 + 16'($urandom_range(255)), 16'd3024, 16'hD843,
                  16'd36477 + 16'($urandom_range(2047))},
                 {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140 + 16'($urandom_range(63))},
                 {48'd0, 16'($urandom)});
    end
  endtask

  // Reset calibration: P1 is zero, so every item hits the zero divisor
  task automatic test_reset_calib();
    send_sample(20'h0, 20'h0);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'h7D000, 20'h5A000);
  endtask

  // Field extremes under typical and extreme coefficients
  task automatic test_directed();
    load_typical();
    send_sample(20'd519888, 20'd415148);
    send_sample(20'h0, 20'h0);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'h0, 20'hFFFFF);
    send_sample(20'hFFFFF, 20'h0);
    send_sample(20'h55555, 20'hAAAAA);
    send_sample(20'hAAAAA, 20'h55555);
    // every register at all ones: saturation corners
    load_calib(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
               64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF);
    send_sample(20'h0, 20'h0);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'h80000, 20'h12345);
    // signed maxima and minima
    load_calib({16'h7FFF, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF},
               {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 64'h7FFF);
    send_sample(20'hFFFFF, 20'h0);
    send_sample(20'h0, 20'hFFFFF);
    load_calib({16'h8000, 16'h8000, 16'h0001}, {16'h8000, 16'h8000, 16'h8000, 16'h0001},
               {16'h8000, 16'h8000, 16'h8000, 16'h8000}, 64'h8000);
    send_sample(20'hFFFFF, 20'h0);
    send_sample(20'h0, 20'hFFFFF);
    send_sample(20'h3C000, 20'h64000);
  endtask

  // Random samples over one idling mode, with a full pause mid phase
  task automatic test_random_phase(input int n_items, input int in_pct, input int out_pct);
    idle_in_pct  = in_pct;
    idle_out_pct = out_pct;
    rand_calib();
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) begin
        drain_pipe();
        rand_calib();
      end
      if ($urandom_range(3) == 0) send_sample(20'($urandom), 20'($urandom));
      else send_sample(20'($urandom_range(420000, 600000)),
                       20'($urandom_range(250000, 500000)));
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    out_stall_i  = 1'b0;
    cal_temp     = '0;
    cal_pa       = '0;
    cal_pb       = '0;
    cal_p9       = '0;
    fail_cnt     = 0;
    sent_cnt     = 0;
    recv_cnt     = 0;
    zero_div_cnt = 0;
    idle_in_pct  = 0;
    idle_out_pct = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_calib();
    test_directed();
    test_random_phase(130, 26, 53);
    test_random_phase(130, 53, 26);
    test_random_phase(130, 0, 0);
    drain_pipe();

    $display("Sent %0d sample items, checked %0d results (%0d with zero divisor)",
             sent_cnt, recv_cnt, zero_div_cnt);
    $display("Covered reset, extreme and random calibration under three idling mixes");
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
